// ===== rtl/core/tans_pkg.sv =====
// ----------------------------------------------------------------------------
// tans_pkg
// shared types, constants and helpers of the tans symbol decoder
// ----------------------------------------------------------------------------
package tans_pkg;
   localparam int MaxSymbols  = 256;
   localparam int MaxTableLog = 12;
   localparam int MinLog      = 5;
   localparam int PeekWidth   = 12;

   localparam logic [2:0] CMD_LOAD   = 3'd0;
   localparam logic [2:0] CMD_BUILD  = 3'd1;
   localparam logic [2:0] CMD_INIT   = 3'd2;
   localparam logic [2:0] CMD_DECODE = 3'd3;
   localparam logic [2:0] CMD_FINISH = 3'd4;

   localparam logic [1:0] REG_TABLE_LOG   = 2'd0;
   localparam logic [1:0] REG_NUM_SYMBOLS = 2'd1;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  symbol_index;
      logic [12:0] count;
      logic [11:0] peek_bits;
   } req_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic [3:0] bits_used;
      logic       status;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic clr_sum;     // clear build accumulators
      logic sum_rd;      // read count at sym counter (sum phase)
      logic sum_acc;     // accumulate read count
      logic spr_wr;      // write symbol at pos, advance
      logic spr_nxt;     // next symbol, write next_counter
      logic fin_rd;      // read table entry sym at index i
      logic fin_rd2;     // latch entry symbol, addressing next_counter
      logic fin_wr;      // write entry fields, bump counter
      logic dec_rd;      // read table at state
      logic dec_upd;     // update state and emit
      logic load_wr;     // write count store
      logic init_upd;    // load state from peek
      logic emit;        // emit generic result
   } ctl_type;

   typedef struct packed {
      logic sym_last;    // symbol counter at last symbol
      logic cnt_done;    // spread count for symbol reached
      logic idx_last;    // finalize index at last entry
      logic sum_bad;     // sum differs from size
   } sts_type;

   // position of the most significant set bit
   function automatic logic [3:0] top_bit(input logic [12:0] v);
      logic [3:0] r;
      r = '0;
      for (int k = 1; k < 13; k++) if (v[k]) r = 4'(k);
      return r;
   endfunction
endpackage

// ===== rtl/core/tans_ram.sv =====
// ----------------------------------------------------------------------------
// tans_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module tans_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// ===== rtl/core/tans_datapath.sv =====
// ----------------------------------------------------------------------------
// tans_datapath
// count store, counters, decode table and state register
// ----------------------------------------------------------------------------
module tans_datapath import tans_pkg::*; #(
   parameter int MAX_SYMBOLS   = MaxSymbols,
   parameter int MAX_TABLE_LOG = MaxTableLog
) (
   input  logic    clock,
   input  logic    reset,
   input  ctl_type ctl,
   output sts_type sts,
   input  req_type req_ff,
   input  logic [3:0] tl,
   input  logic [8:0] ns,
   output rsp_type rsp
);
   localparam int SW = $clog2(MAX_SYMBOLS);
   localparam int TW = MAX_TABLE_LOG;

   logic [12:0] size;
   logic [TW-1:0] mask, step;
   assign size = 13'(1) << tl;
   assign mask = TW'(size - 13'd1);
   assign step = TW'((size >> 1) + (size >> 3) + 13'd3);

   logic [SW:0]    sidx_ff, sidx_in;
   logic [12:0]    n_ff, n_in;
   logic [20:0]    sum_ff, sum_in;
   logic [TW-1:0]  pos_ff, pos_in;
   logic [TW-1:0]  st_ff, st_in;
   logic [TW-1:0]  ent_ff;
   logic [7:0]     esym_ff, esym_in;

   // count store
   logic           cs_we;
   logic [SW-1:0]  cs_addr;
   logic [12:0]    cs_rd;
   assign cs_we   = ctl.load_wr && ({1'b0, req_ff.symbol_index} < 9'(MAX_SYMBOLS));
   assign cs_addr = ctl.load_wr ? SW'(req_ff.symbol_index) : sidx_ff[SW-1:0];
   tans_ram #(.Width(13), .Depth(MAX_SYMBOLS)) u_cnt (
      .clock, .we(cs_we), .addr(cs_addr), .wdata(req_ff.count), .rdata(cs_rd));

   // next counter
   logic           nc_we;
   logic [SW-1:0]  nc_addr;
   logic [12:0]    nc_wd, nc_rd;
   assign nc_we   = ctl.spr_nxt || ctl.fin_wr;
   assign nc_addr = ctl.spr_nxt ? sidx_ff[SW-1:0] : SW'(esym_ff);
   assign nc_wd   = ctl.spr_nxt ? cs_rd : nc_rd + 13'd1;
   tans_ram #(.Width(13), .Depth(MAX_SYMBOLS)) u_nxt (
      .clock, .we(nc_we), .addr(nc_addr), .wdata(nc_wd), .rdata(nc_rd));

   // decode table {base, nbits, sym}
   logic           dt_we;
   logic [TW-1:0]  dt_addr;
   logic [23:0]    dt_wd, dt_rd;
   logic [12:0]    nx;
   logic [3:0]     nb;
   logic [12:0]    base;
   assign nx   = (nc_rd == 13'd0) ? 13'd1 : nc_rd;
   assign nb   = tl - top_bit(nx);
   assign base = 13'((nx << nb) - size) & 13'(mask);
   assign dt_we = ctl.spr_wr || ctl.fin_wr;
   always_comb begin
      dt_addr = pos_ff;
      if (ctl.dec_rd) dt_addr = st_ff & mask;
      else if (ctl.fin_rd || ctl.fin_wr) dt_addr = ent_ff;
      if (ctl.spr_wr) dt_wd = {dt_rd[23:8], 8'(sidx_ff)};
      else dt_wd = {base[11:0], nb, esym_ff};
   end
   tans_ram #(.Width(24), .Depth(1 << TW)) u_tab (
      .clock, .we(dt_we), .addr(dt_addr), .wdata(dt_wd), .rdata(dt_rd));

   logic [TW-1:0] ent_in;
   logic [3:0]    dnb;
   logic [TW-1:0] peek_n;
   assign dnb = (dt_rd[11:8] > tl) ? tl : dt_rd[11:8];
   assign peek_n = TW'(({12'd0, req_ff.peek_bits} << dnb) >> PeekWidth);

   always_comb begin
      sidx_in = sidx_ff; n_in = n_ff; sum_in = sum_ff; pos_in = pos_ff;
      st_in = st_ff; ent_in = ent_ff; esym_in = esym_ff;
      if (ctl.clr_sum) begin
         sidx_in = '0; n_in = '0; sum_in = '0; pos_in = '0; ent_in = '0;
      end
      if (ctl.sum_acc) begin
         sum_in = sum_ff + 21'(cs_rd);
         sidx_in = sidx_ff + 1'b1;
         if (sts.sym_last) sidx_in = '0;
      end
      if (ctl.spr_wr) begin
         pos_in = (pos_ff + step) & mask;
         n_in = n_ff + 13'd1;
      end
      if (ctl.spr_nxt) begin
         sidx_in = sidx_ff + 1'b1; n_in = '0;
      end
      if (ctl.fin_rd2) esym_in = (dt_rd[7:0] >= 8'(MAX_SYMBOLS - 1) &&
                                  MAX_SYMBOLS < 256 &&
                                  {1'b0, dt_rd[7:0]} >= 9'(MAX_SYMBOLS)) ? 8'd0 : dt_rd[7:0];
      if (ctl.fin_wr) ent_in = ent_ff + 1'b1;
      if (ctl.init_upd) st_in = TW'(({12'd0, req_ff.peek_bits} << tl) >> PeekWidth) & mask;
      if (ctl.dec_upd) st_in = (TW'(dt_rd[23:12]) + peek_n) & mask;
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= '0;
      else st_ff <= st_in;
      sidx_ff <= sidx_in; n_ff <= n_in; sum_ff <= sum_in; pos_ff <= pos_in;
      ent_ff <= ent_in; esym_ff <= esym_in;
   end

   assign sts.sym_last = (9'(sidx_ff) == ns - 9'd1);
   assign sts.cnt_done = (n_ff >= cs_rd);
   assign sts.idx_last = (ent_ff == mask);
   assign sts.sum_bad  = (sum_ff != 21'(size));

   always_comb begin
      rsp = '0;
      unique case (req_ff.cmd)
         CMD_BUILD:  rsp.status = sts.sum_bad;
         CMD_INIT:   rsp.bits_used = tl;
         CMD_DECODE: begin
            rsp.symbol = dt_rd[7:0];
            rsp.bits_used = dnb;
         end
         CMD_FINISH: rsp.symbol = 8'(st_ff);
         default: rsp = '0;
      endcase
   end
endmodule

// ===== rtl/core/tans_ctrl.sv =====
// ----------------------------------------------------------------------------
// tans_ctrl
// command sequencer of the tans symbol decoder
// ----------------------------------------------------------------------------
module tans_ctrl import tans_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [2:0] cmd,
   input  sts_type    sts,
   output ctl_type    ctl,
   output logic       busy,
   output logic       done
);
   localparam logic [3:0] S_IDLE = 4'd0, S_EXEC = 4'd1, S_SRD = 4'd2, S_SACC = 4'd3,
                          S_CHK = 4'd4, S_PRD = 4'd5, S_PWAIT = 4'd6, S_PLOOP = 4'd7,
                          S_FRD = 4'd8, S_FRD2 = 4'd9, S_FWR = 4'd10, S_DRD = 4'd11,
                          S_DUPD = 4'd12, S_DONE = 4'd13;
   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      done = 1'b0;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_EXEC;
         S_EXEC: begin
            unique case (cmd)
               CMD_LOAD:   begin ctl.load_wr = 1'b1; done = 1'b1; state_in = S_IDLE; end
               CMD_BUILD:  begin ctl.clr_sum = 1'b1; state_in = S_SRD; end
               CMD_INIT:   begin ctl.init_upd = 1'b1; done = 1'b1; state_in = S_IDLE; end
               CMD_DECODE: begin ctl.dec_rd = 1'b1; state_in = S_DUPD; end
               default:    begin done = 1'b1; state_in = S_IDLE; end
            endcase
         end
         S_SRD:  state_in = S_SACC;
         S_SACC: begin
            ctl.sum_acc = 1'b1;
            state_in = sts.sym_last ? S_CHK : S_SRD;
         end
         S_CHK: begin
            if (sts.sum_bad) begin done = 1'b1; state_in = S_IDLE; end
            else state_in = S_PRD;
         end
         S_PRD:   state_in = S_PWAIT;
         S_PWAIT: state_in = S_PLOOP;
         S_PLOOP: begin
            if (sts.cnt_done) begin
               ctl.spr_nxt = 1'b1;
               state_in = sts.sym_last ? S_FRD : S_PRD;
            end else begin
               ctl.spr_wr = 1'b1;
               state_in = S_PWAIT;
            end
         end
         S_FRD:  begin ctl.fin_rd = 1'b1; state_in = S_FRD2; end
         S_FRD2: begin ctl.fin_rd2 = 1'b1; ctl.fin_rd = 1'b1; state_in = S_DONE; end
         S_DONE: begin ctl.fin_rd = 1'b1; state_in = S_FWR; end
         S_FWR: begin
            ctl.fin_wr = 1'b1;
            if (sts.idx_last) begin done = 1'b1; state_in = S_IDLE; end
            else state_in = S_FRD;
         end
         S_DRD:  state_in = S_DUPD;
         S_DUPD: begin ctl.dec_upd = 1'b1; done = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

// ===== rtl/core/tans_symbol_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tans_symbol_decoder_unit
// table-driven ans symbol decoder: count load, table build, init, finish, decode
// ----------------------------------------------------------------------------
// channel   ports                      handshake
// request   start, busy, req_data      start while busy low
// result    rsp_valid, rsp_data        one-cycle strobe, no stall
// csr       psel..pready               apb write at access phase
//
// load, init, finish: result valid in the same cycle busy drops
// decode: one table read per request
// build: a bad count sum ends the build after the sum check
// reset clears the state register, controller, rsp_valid and csr registers; stores stay unwritten
// results cannot be stalled; busy holds off new requests
// ----------------------------------------------------------------------------
module tans_symbol_decoder_unit import tans_pkg::*; #(
   parameter int MAX_SYMBOLS   = MaxSymbols,
   parameter int MAX_TABLE_LOG = MaxTableLog
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   ctl_type ctl;
   sts_type sts;
   req_type req_ff;
   logic    done;
   rsp_type rsp;
   logic [3:0] tlog_ff;
   logic [8:0] nsym_ff;
   logic [3:0] tl;
   logic [8:0] ns;

   assign pready = 1'b1;

   // clamp registers where used
   always_comb begin
      tl = tlog_ff;
      if (tl < 4'(MinLog)) tl = 4'(MinLog);
      if (tl > 4'(MAX_TABLE_LOG)) tl = 4'(MAX_TABLE_LOG);
      ns = nsym_ff;
      if (ns == 9'd0) ns = 9'd1;
      if (ns > 9'(MAX_SYMBOLS)) ns = 9'(MAX_SYMBOLS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlog_ff <= 4'd12;
         nsym_ff <= 9'd256;
         rsp_valid <= 1'b0;
      end else begin
         if (psel && penable && pwrite) begin
            if (paddr[2] == REG_NUM_SYMBOLS[0]) nsym_ff <= pwdata[8:0];
            else if (paddr[2] == REG_TABLE_LOG[0]) tlog_ff <= pwdata[3:0];
         end
         rsp_valid <= done;
      end
      if (start && !busy) req_ff <= req_data;
      if (done) rsp_data <= rsp;
   end

   always_comb begin
      prdata = '0;
      if (paddr[2]) prdata = {23'd0, nsym_ff};
      else prdata = {28'd0, tlog_ff};
   end

   tans_ctrl u_ctrl (
      .clock, .reset, .start, .cmd(req_ff.cmd), .sts, .ctl, .busy, .done);

   tans_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS), .MAX_TABLE_LOG(MAX_TABLE_LOG)) u_dp (
      .clock, .reset, .ctl, .sts, .req_ff, .tl, .ns, .rsp);
endmodule
